>>> rtl/cpfm_pkg.sv
`default_nettype none
package cpfm_pkg;

	localparam int COORD_BITS_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int OUT_BITS          = 32;
	localparam int ROWS              = 4;

	typedef struct packed {
		logic signed [31:0] top_left_r;
		logic signed [31:0] top_left_a;
		logic signed [31:0] top_left_s;
		logic signed [31:0] top_right_r;
		logic signed [31:0] top_right_a;
		logic signed [31:0] top_right_s;
		logic signed [31:0] bottom_right_r;
		logic signed [31:0] bottom_right_a;
		logic signed [31:0] bottom_right_s;
	} corners_t;

	typedef struct packed {
		logic [1:0]         row_number;
		logic signed [31:0] col_x;
		logic signed [31:0] col_y;
		logic signed [31:0] col_z;
		logic signed [31:0] col_t;
		logic               last_row;
	} row_t;

	// two normalized axes and the translation of one frame, as held in the frame store
	typedef struct packed {
		logic signed [31:0] ux0;
		logic signed [31:0] ux1;
		logic signed [31:0] ux2;
		logic signed [31:0] uy0;
		logic signed [31:0] uy1;
		logic signed [31:0] uy2;
		logic signed [31:0] t0;
		logic signed [31:0] t1;
		logic signed [31:0] t2;
	} frame_t;

endpackage
`default_nettype wire

>>> rtl/cpfm_unit.sv
`default_nettype none
// Normalize one difference vector. The pipeline advances when en is high.
// Stages: magnitude, scaling shift, squares and sum, bit-serial square root (16 stages of
// two bits), then three restoring dividers sharing the depth (one quotient bit a stage).
module cpfm_unit #(
	parameter int COORD_BITS    = cpfm_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = cpfm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [COORD_BITS:0]    d0,
	input  wire logic signed [COORD_BITS:0]    d1,
	input  wire logic signed [COORD_BITS:0]    d2,
	output      logic signed [FRACTION_BITS+2:0] u0,
	output      logic signed [FRACTION_BITS+2:0] u1,
	output      logic signed [FRACTION_BITS+2:0] u2
);
	localparam int DW  = COORD_BITS + 1;
	localparam int SQ  = 16;               // sqrt stages, result 31 bits max of 62-bit sum
	localparam int QW  = FRACTION_BITS + 2; // quotient bits: value <= 2^F
	localparam int NW  = 30 + FRACTION_BITS; // numerator width
	localparam int SW  = $clog2(DW + 1);

	// stage 1: signs and magnitudes
	logic [DW-1:0] m_s1 [3];
	logic [2:0]    sg_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s1   <= {d2[DW-1], d1[DW-1], d0[DW-1]};
			m_s1[0] <= d0[DW-1] ? DW'(-d0) : DW'(d0);
			m_s1[1] <= d1[DW-1] ? DW'(-d1) : DW'(d1);
			m_s1[2] <= d2[DW-1] ? DW'(-d2) : DW'(d2);
		end
	end

	// stage 2: find leading one of the max, shift so max in [2^29, 2^30)
	logic [DW-1:0] mx;
	logic [SW-1:0] lead;
	always_comb begin
		mx = m_s1[0] | m_s1[1] | m_s1[2];
		lead = '0;
		for (int i = 0; i < DW; i++)
			if (mx[i]) lead = SW'(i);
	end
	logic [29:0] n_s2 [3];
	logic [2:0]  sg_s2;
	logic        z_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s2 <= sg_s1;
			z_s2  <= (mx == '0);
			for (int i = 0; i < 3; i++) begin
				if (lead >= SW'(29))
					n_s2[i] <= 30'(m_s1[i] >> (lead - SW'(29)));
				else
					n_s2[i] <= 30'({{(30 > DW ? 30 - DW : 0){1'b0}}, m_s1[i]} << (SW'(29) - lead));
			end
		end
	end

	// stage 3: squares
	logic [59:0] p_s3 [3];
	logic [29:0] n_s3 [3];
	logic [2:0]  sg_s3;
	logic        z_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s3 <= sg_s2; z_s3 <= z_s2;
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= 60'(n_s2[i]) * 60'(n_s2[i]);
				n_s3[i] <= n_s2[i];
			end
		end
	end

	// stage 4: sum
	logic [61:0] sum_s4;
	logic [29:0] n_s4 [3];
	logic [2:0]  sg_s4;
	logic        z_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			sg_s4 <= sg_s3; z_s4 <= z_s3; n_s4 <= n_s3;
			sum_s4 <= 62'(p_s3[0]) + 62'(p_s3[1]) + 62'(p_s3[2]);
		end
	end

	// square root: two result bits per stage group, 31 result bits over SQ stages
	logic [61:0] rem_q [1:SQ];
	logic [30:0] root_q [1:SQ];
	logic [29:0] nr_q [1:SQ][3];
	logic [2:0]  sgr_q [1:SQ];
	logic        zr_q [1:SQ];
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		logic [61:0] rem_in;
		logic [30:0] root_in;
		logic [29:0] n_in [3];
		logic [2:0]  sg_in;
		logic        z_in;
		logic [63:0] r;
		logic [31:0] q;
		if (k == 0) begin : g_head
			assign rem_in  = sum_s4;
			assign root_in = '0;
			assign n_in    = n_s4;
			assign sg_in   = sg_s4;
			assign z_in    = z_s4;
		end else begin : g_tail
			assign rem_in  = rem_q[k];
			assign root_in = root_q[k];
			assign n_in    = nr_q[k];
			assign sg_in   = sgr_q[k];
			assign z_in    = zr_q[k];
		end
		always_comb begin
			r = {2'b0, rem_in};
			q = {1'b0, root_in};
			for (int j = 0; j < 2; j++) begin
				// bit position b = 30 - 2k - j; skip positions below bit zero
				if (30 - 2 * k - j >= 0) begin
					if ({r[63:0]} >= (({32'b0, q} << (31 - 2 * k - j))
						| (64'b1 << (2 * (30 - 2 * k - j))))) begin
						r = r - ((({32'b0, q} << (31 - 2 * k - j)))
							| (64'b1 << (2 * (30 - 2 * k - j))));
						q = q | (32'b1 << (30 - 2 * k - j));
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= r[61:0];
				root_q[k+1] <= q[30:0];
				nr_q[k+1]   <= n_in;
				sgr_q[k+1]  <= sg_in;
				zr_q[k+1]   <= z_in;
			end
		end
	end

	// divide: quotient of (n<<F + L/2) / L, one bit per stage, QW stages
	logic [NW:0]   num_q [1:QW][3];
	logic [QW-1:0] quo_q [1:QW][3];
	logic [30:0]   len_q [1:QW];
	logic [2:0]    sgd_q [1:QW];
	logic          zd_q  [1:QW];
	logic [NW:0]   num_first [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			num_first[i] = (NW + 1)'({nr_q[SQ][i], {FRACTION_BITS{1'b0}}})
				+ (NW + 1)'(root_q[SQ] >> 1);
	end
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW:0]    num_in [3];
		logic [QW-1:0]  quo_in [3];
		logic [30:0]    len_in;
		logic [2:0]     sg_in;
		logic           z_in;
		logic [NW:0]    nn [3];
		logic [QW-1:0]  qq [3];
		logic [NW+QW:0] dv;
		if (k == 0) begin : g_head
			assign num_in = num_first;
			assign quo_in = '{default: '0};
			assign len_in = root_q[SQ];
			assign sg_in  = sgr_q[SQ];
			assign z_in   = zr_q[SQ];
		end else begin : g_tail
			assign num_in = num_q[k];
			assign quo_in = quo_q[k];
			assign len_in = len_q[k];
			assign sg_in  = sgd_q[k];
			assign z_in   = zd_q[k];
		end
		always_comb begin
			dv = (NW + QW + 1)'(len_in) << (QW - 1 - k);
			for (int i = 0; i < 3; i++) begin
				nn[i] = num_in[i];
				qq[i] = quo_in[i];
				if ((NW + QW + 1)'(num_in[i]) >= dv) begin
					nn[i] = (NW + 1)'((NW + QW + 1)'(num_in[i]) - dv);
					qq[i][QW-1-k] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				num_q[k+1] <= nn; quo_q[k+1] <= qq;
				len_q[k+1] <= len_in; sgd_q[k+1] <= sg_in; zd_q[k+1] <= z_in;
			end
		end
	end

	always_comb begin
		u0 = zd_q[QW] ? '0 : (sgd_q[QW][0] ? -$signed({1'b0, quo_q[QW][0]})
			: $signed({1'b0, quo_q[QW][0]}));
		u1 = zd_q[QW] ? '0 : (sgd_q[QW][1] ? -$signed({1'b0, quo_q[QW][1]})
			: $signed({1'b0, quo_q[QW][1]}));
		u2 = zd_q[QW] ? '0 : (sgd_q[QW][2] ? -$signed({1'b0, quo_q[QW][2]})
			: $signed({1'b0, quo_q[QW][2]}));
	end
endmodule
`default_nettype wire

>>> rtl/corner_points_to_frame_matrix.sv
// Data path is input differences, two normalizing units, cross products, rounding, frame store.
// Corner sets overlap in the pipeline, each held off by a spacing gap and by frame-store credit;
// rows leave one per cycle while out_ready is high, four per frame from the output serializer.
// Reset: arst_n clears all valid bits and the row counter; data registers keep no reset.
`default_nettype none
module corner_points_to_frame_matrix #(
	parameter int COORD_BITS    = cpfm_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = cpfm_pkg::FRACTION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire cpfm_pkg::corners_t in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      cpfm_pkg::row_t     out_data
);
	localparam int QW   = FRACTION_BITS + 2;
	localparam int LAT  = 4 + 16 + QW;
	localparam int UW   = FRACTION_BITS + 3;
	localparam int OB   = (COORD_BITS < cpfm_pkg::OUT_BITS) ? COORD_BITS : cpfm_pkg::OUT_BITS;

	// frame fifo holding finished matrices; credits keep the pipe from overrunning it
	localparam int FD   = 16;
	localparam int FAW  = $clog2(FD);

	logic en;
	assign en = 1'b1;

	function automatic logic signed [COORD_BITS-1:0] sx(input logic [31:0] v);
		return COORD_BITS'(signed'({{(COORD_BITS > 32 ? COORD_BITS - 32 : 0){v[31]}}, v}));
	endfunction

	logic signed [COORD_BITS-1:0] tl [3], tr [3], br [3];
	always_comb begin
		tl[0] = sx(in_data.top_left_r);     tl[1] = sx(in_data.top_left_a);
		tl[2] = sx(in_data.top_left_s);     tr[0] = sx(in_data.top_right_r);
		tr[1] = sx(in_data.top_right_a);    tr[2] = sx(in_data.top_right_s);
		br[0] = sx(in_data.bottom_right_r); br[1] = sx(in_data.bottom_right_a);
		br[2] = sx(in_data.bottom_right_s);
	end

	// input stage: differences and midpoint, valid travels alongside
	logic                        v_s1;
	logic signed [COORD_BITS:0]  dx_s1 [3], dy_s1 [3], t_s1 [3];
	logic [4:0]                  gap_q;
	logic [FAW:0]                cnt_q;
	logic                        acc;
	assign in_ready = (gap_q == '0) && (cnt_q < (FAW + 1)'(FD));
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dx_s1[i] <= (COORD_BITS + 1)'(tr[i]) - (COORD_BITS + 1)'(tl[i]);
			dy_s1[i] <= (COORD_BITS + 1)'(tr[i]) - (COORD_BITS + 1)'(br[i]);
			t_s1[i]  <= ((COORD_BITS + 1)'(tl[i]) + (COORD_BITS + 1)'(br[i])) >>> 1;
		end
	end

	logic signed [UW-1:0] ux [3], uy [3];
	cpfm_unit #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_x (
		.clk(clk), .en(en), .d0(dx_s1[0]), .d1(dx_s1[1]), .d2(dx_s1[2]),
		.u0(ux[0]), .u1(ux[1]), .u2(ux[2]));
	cpfm_unit #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_y (
		.clk(clk), .en(en), .d0(dy_s1[0]), .d1(dy_s1[1]), .d2(dy_s1[2]),
		.u0(uy[0]), .u1(uy[1]), .u2(uy[2]));

	// valid and translation delay line matching the unit
	logic                       vd_q [1:LAT];
	logic signed [COORD_BITS:0] td_q [1:LAT][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 1; k <= LAT; k++) vd_q[k] <= 1'b0;
		end else begin
			v_s1 <= acc;
			vd_q[1] <= v_s1;
			for (int k = 2; k <= LAT; k++) vd_q[k] <= vd_q[k-1];
		end
	end
	always_ff @(posedge clk) begin
		td_q[1] <= t_s1;
		for (int k = 2; k <= LAT; k++) td_q[k] <= td_q[k-1];
	end

	// cross-product products, then difference and rounding
	localparam int PW = 2 * UW;
	logic signed [PW-1:0] pa_s1 [3], pb_s1 [3];
	logic                 vc_s1, vc_s2;
	logic signed [UW-1:0] ux_s1 [3], uy_s1 [3], ux_s2 [3], uy_s2 [3];
	logic signed [COORD_BITS:0] tc_s1 [3], tc_s2 [3];
	logic signed [PW:0]   z_s2 [3];
	always_ff @(posedge clk) begin
		pa_s1[0] <= PW'(ux[1]) * PW'(uy[2]); pb_s1[0] <= PW'(uy[1]) * PW'(ux[2]);
		pa_s1[1] <= PW'(uy[0]) * PW'(ux[2]); pb_s1[1] <= PW'(ux[0]) * PW'(uy[2]);
		pa_s1[2] <= PW'(ux[0]) * PW'(uy[1]); pb_s1[2] <= PW'(uy[0]) * PW'(ux[1]);
		ux_s1 <= ux; uy_s1 <= uy; tc_s1 <= td_q[LAT];
		ux_s2 <= ux_s1; uy_s2 <= uy_s1; tc_s2 <= tc_s1;
		for (int i = 0; i < 3; i++) begin
			logic signed [PW:0] p;
			logic [PW:0]        m;
			p = (PW + 1)'(pa_s1[i]) - (PW + 1)'(pb_s1[i]);
			m = p[PW] ? (PW + 1)'(-p) : (PW + 1)'(p);
			m = (m + ((PW + 1)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
			z_s2[i] <= p[PW] ? -$signed(m) : $signed(m);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_s1 <= 1'b0; vc_s2 <= 1'b0;
		end else begin
			vc_s1 <= vd_q[LAT]; vc_s2 <= vc_s1;
		end
	end

	function automatic logic signed [31:0] sat(input logic signed [PW+COORD_BITS:0] v);
		logic signed [PW+COORD_BITS:0] hi, lo;
		logic signed [OB-1:0]          r;
		hi = (PW + COORD_BITS + 1)'((64'sd1 <<< (OB - 1)) - 64'sd1);
		lo = -hi - 1;
		if (v > hi) r = {1'b0, {(OB - 1){1'b1}}};
		else if (v < lo) r = {1'b1, {(OB - 1){1'b0}}};
		else r = OB'(v);
		return 32'(signed'(r));
	endfunction

	// frame store
	cpfm_pkg::frame_t         f_mem [FD];
	logic signed [31:0]       fz_mem [FD][3];
	logic [FAW-1:0]           wp_q, rp_q;
	logic [1:0]               row_q;
	logic                     pop;
	assign pop = out_valid && out_ready && (row_q == 2'd3);
	always_ff @(posedge clk) begin
		if (vc_s2) begin
			f_mem[wp_q] <= '{sat($signed(ux_s2[0])), sat($signed(ux_s2[1])),
				sat($signed(ux_s2[2])), sat($signed(uy_s2[0])), sat($signed(uy_s2[1])),
				sat($signed(uy_s2[2])), sat($signed(tc_s2[0])), sat($signed(tc_s2[1])),
				sat($signed(tc_s2[2]))};
			for (int i = 0; i < 3; i++) fz_mem[wp_q][i] <= sat($signed(z_s2[i]));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; row_q <= '0; gap_q <= '0;
		end else begin
			if (acc) cnt_q <= cnt_q + 1'b1 - (FAW + 1)'(pop);
			else if (pop) cnt_q <= cnt_q - 1'b1;
			gap_q <= acc ? 5'd3 : (gap_q != '0 ? gap_q - 1'b1 : gap_q);
			if (vc_s2) wp_q <= (wp_q == FAW'(FD - 1)) ? '0 : wp_q + 1'b1;
			if (out_valid && out_ready) begin
				row_q <= row_q + 1'b1;
				if (row_q == 2'd3) rp_q <= (rp_q == FAW'(FD - 1)) ? '0 : rp_q + 1'b1;
			end
		end
	end

	logic [FAW:0] avail_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) avail_q <= '0;
		else avail_q <= avail_q + (FAW + 1)'(vc_s2) - (FAW + 1)'(pop);
	end
	assign out_valid = (avail_q != '0);

	cpfm_pkg::frame_t f;
	assign f = f_mem[rp_q];
	always_comb begin
		out_data.row_number = row_q;
		out_data.last_row   = (row_q == 2'd3);
		case (row_q)
			2'd0: out_data = '{2'd0, f.ux0, f.uy0, fz_mem[rp_q][0], f.t0, 1'b0};
			2'd1: out_data = '{2'd1, f.ux1, f.uy1, fz_mem[rp_q][1], f.t1, 1'b0};
			2'd2: out_data = '{2'd2, f.ux2, f.uy2, fz_mem[rp_q][2], f.t2, 1'b0};
			default: out_data = '{2'd3, 32'sd0, 32'sd0, 32'sd0,
				32'(1 << FRACTION_BITS), 1'b1};
		endcase
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		avail_q <= cnt_q) else $error("frame store ahead of credits");
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_row |=> row_q == 2'd0)
		else $error("row counter out of step");
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !in_ready) else $error("accepts closer than four cycles");
`endif
endmodule
`default_nettype wire

>>> verif/testbench.sv
`default_nettype none
module testbench;

	localparam int FB = 16;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	cpfm_pkg::corners_t in_data;
	logic               out_valid;
	logic               out_ready;
	cpfm_pkg::row_t     out_data;

	cpfm_pkg::corners_t corner_queue[$];
	cpfm_pkg::row_t     row_queue[$];
	int       mismatches;
	bit       pause_req;
	int       gap_left;
	int       burst_left;
	int       stall_phase;

	corner_points_to_frame_matrix u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// scale a difference vector to unit length; zero stays zero
	task automatic unit_axis(input longint d[3], output longint u[3]);
		longint unsigned mag[3], m, sum, len, q;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = d[i] < 0 ? -d[i] : d[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			u[0] = 0; u[1] = 0; u[2] = 0;
			return;
		end
		while (m >= (64'd1 << 30)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		len = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << FB) + (len >> 1)) / len;
			u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
		end
	endtask

	function automatic longint round_product(longint p);
		longint unsigned mag;
		mag = p < 0 ? -p : p;
		mag = (mag + (64'd1 << (FB - 1))) >> FB;
		return p < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	task automatic predict_frame(input cpfm_pkg::corners_t c);
		longint tl[3], tr[3], br[3], mid[3], dx[3], dy[3], ux[3], uy[3], uz[3], s;
		cpfm_pkg::row_t r;
		tl = '{c.top_left_r, c.top_left_a, c.top_left_s};
		tr = '{c.top_right_r, c.top_right_a, c.top_right_s};
		br = '{c.bottom_right_r, c.bottom_right_a, c.bottom_right_s};
		for (int i = 0; i < 3; i++) begin
			s = tl[i] + br[i];
			mid[i] = s >>> 1;
			dx[i] = tr[i] - tl[i];
			dy[i] = tr[i] - br[i];
		end
		unit_axis(dx, ux);
		unit_axis(dy, uy);
		uz[0] = round_product(ux[1] * uy[2] - uy[1] * ux[2]);
		uz[1] = round_product(uy[0] * ux[2] - ux[0] * uy[2]);
		uz[2] = round_product(ux[0] * uy[1] - uy[0] * ux[1]);
		for (int i = 0; i < 3; i++) begin
			r.row_number = 2'(i);
			r.col_x = 32'(sat32(ux[i]));
			r.col_y = 32'(sat32(uy[i]));
			r.col_z = 32'(sat32(uz[i]));
			r.col_t = 32'(sat32(mid[i]));
			r.last_row = 1'b0;
			row_queue.push_back(r);
		end
		r = '{row_number: 2'd3, col_x: 0, col_y: 0, col_z: 0,
			col_t: 32'sd1 << FB, last_row: 1'b1};
		row_queue.push_back(r);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 2000) - 1000;
			2: return $urandom_range(0, 255) << 16;
			default: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
		endcase
	endfunction

	task automatic push_corners(logic [31:0] v[9]);
		corner_queue.push_back(cpfm_pkg::corners_t'({v[0], v[1], v[2], v[3], v[4], v[5],
			v[6], v[7], v[8]}));
	endtask

	// driver: bursts with random gaps, or hold off while pause_req is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) predict_frame(in_data);
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (corner_queue.size() > 0 && !pause_req) begin
				in_valid <= 1'b1;
				in_data <= corner_queue.pop_front();
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor, plus a receiver stall pattern that drifts through phases
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if ((stall_phase / 200) % 3 == 0) out_ready <= 1'b1;
			else if ((stall_phase / 200) % 3 == 1) out_ready <= (stall_phase % 7) < 4;
			else out_ready <= $urandom_range(0, 3) != 0;
			if (out_valid && out_ready) begin
				if (row_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected row beat: %p", out_data);
				end else begin
					cpfm_pkg::row_t exp_row;
					exp_row = row_queue.pop_front();
					if (out_data !== exp_row) begin
						mismatches++;
						if (mismatches <= 10)
							$display("row mismatch: expected %p got %p", exp_row, out_data);
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [31:0] v[9];
		int mode;
		mismatches = 0;
		pause_req = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero-length axes, degenerate and unit frames
		v = '{default: 32'h0};
		push_corners(v);
		v = '{default: 32'h7fffffff};
		push_corners(v);
		v = '{default: 32'h80000000};
		push_corners(v);
		v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000};
		push_corners(v);
		v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
		push_corners(v);
		v = '{0, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'hffff0000, 0};
		push_corners(v);
		v = '{5, 6, 7, 5, 6, 7, 1, 2, 3};
		push_corners(v);
		v = '{1, 2, 3, 9, 9, 9, 9, 9, 9};
		push_corners(v);
		v = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0, 0, 0};
		push_corners(v);
		v = '{0, 0, 0, 1, 0, 0, 1, 1, 0};
		push_corners(v);
		v = '{32'hffffffff, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hfffffffe, 32'h1, 32'h3};
		push_corners(v);
		v = '{0, 0, 0, 32'h3fffffff, 32'h3fffffff, 32'h3fffffff, 0, 32'h7fffffff, 0};
		push_corners(v);

		for (int n = 0; n < 120; n++) begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 9; i++) v[i] = rand_coord(mode);
			if ($urandom_range(0, 9) == 0) v[3:5] = v[0:2];
			else if ($urandom_range(0, 9) == 0) v[3:5] = v[6:8];
			push_corners(v);
			if (n == 40) begin
				// hold the sender with beats still queued until every row is back
				while (corner_queue.size() > 20) @(negedge clk);
				pause_req = 1'b1;
				@(negedge clk);
				while (in_valid || row_queue.size() != 0) @(negedge clk);
				pause_req = 1'b0;
			end
		end

		while (corner_queue.size() != 0 || in_valid || row_queue.size() != 0)
			@(negedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && row_queue.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
rtl/cpfm_pkg.sv
rtl/cpfm_unit.sv
rtl/corner_points_to_frame_matrix.sv
verif/testbench.sv
